@@ hdl/sse_pkg.sv @@
// Package for the sorted stack engine: command codes, status codes, field widths.
// Depends on nothing; used by the top module, the checker and the testbench, not by sse_ram.
package sse_pkg;
  localparam logic [2:0] OP_PUSH   = 3'd0;
  localparam logic [2:0] OP_POP    = 3'd1;
  localparam logic [2:0] OP_INSERT = 3'd2;
  localparam logic [2:0] OP_SEARCH = 3'd3;
  localparam logic [2:0] OP_MIN    = 3'd4;
  localparam logic [2:0] OP_SIZE   = 3'd5;
  localparam logic [2:0] OP_SORT   = 3'd6;
  localparam logic [2:0] OP_SPARE  = 3'd7; // unused: no change, status ok, value zero

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  localparam int VAL_W = 32;
  localparam int CNT_W = 7;

  typedef logic signed [VAL_W-1:0] word_t;
endpackage

@@ hdl/sse_ram.sv @@
// Generic simple dual-port RAM with registered read, one write port.
// Depends on nothing.
module sse_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // Write and read, read data registered
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

@@ hdl/sorted_stack_engine_top.sv @@
// Sorted stack engine: bounded stack of signed words under one command per input word.
// Push, size and a failed command go straight to the result; pop reads the top entry;
// search and minimum walk the entries; sorted insert and sort shift entries as they walk.
// busy holds from acceptance to the end of the strobe; a new word is taken after it.
// rst_n (synchronous) clears count and sequencer; RAM contents are left undefined.
// The receiver cannot stall: out_valid lasts one cycle.
module sorted_stack_engine_top
  import sse_pkg::*;
#(
  parameter int STACK_DEPTH = 64
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  output logic                    busy,
  input  logic [2:0]              in_opcode,
  input  logic signed [VAL_W-1:0] in_operand_value,
  output logic                    out_valid,
  output logic [1:0]              out_status,
  output logic signed [VAL_W-1:0] out_result_value,
  output logic [CNT_W-1:0]        out_entry_count
);
  localparam int AW = $clog2(STACK_DEPTH);
  localparam int NW = $clog2(STACK_DEPTH + 1);
  localparam logic [NW-1:0] DEPTH_N = NW'(STACK_DEPTH);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_RD    = 3'd1; // read issued, wait for data
  localparam logic [2:0] S_EVAL  = 3'd2; // compare with read data
  localparam logic [2:0] S_DONE  = 3'd3;
  localparam logic [2:0] S_SKEY  = 3'd4; // sort: key read wait
  localparam logic [2:0] S_SKEYD = 3'd5; // insert, sort: key written at p

  logic [2:0]    state_r, state_nxt;
  logic [2:0]    op_r, op_nxt;
  word_t         val_r, val_nxt;
  word_t         acc_r, acc_nxt;
  logic [NW-1:0] cnt_r, cnt_nxt;
  logic [NW-1:0] p_r, p_nxt;    // walk pointer (index+1 of entry being read)
  logic [NW-1:0] i_r, i_nxt;    // sort outer index
  logic [1:0]    st_r, st_nxt;
  logic          ov_r, ov_nxt;
  logic          srch_hit_r, srch_hit_nxt;

  logic          we;
  logic [AW-1:0] waddr, raddr;
  word_t         wdata, rdata;
  logic          cmp_lt, cmp_eq;
  word_t         cmp_ref;

  sse_ram #(.WIDTH(VAL_W), .DEPTH(STACK_DEPTH)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  // Shared comparator: stored word against the reference word
  assign cmp_ref = (op_r == OP_MIN) ? acc_r : val_r;
  assign cmp_lt  = rdata < cmp_ref;
  assign cmp_eq  = rdata == cmp_ref;

  // Sequencer
  always_comb begin
    state_nxt = state_r; op_nxt = op_r; val_nxt = val_r; acc_nxt = acc_r;
    cnt_nxt = cnt_r; p_nxt = p_r; i_nxt = i_r; st_nxt = st_r; ov_nxt = 1'b0;
    srch_hit_nxt = srch_hit_r;
    we = 1'b0; waddr = '0; wdata = val_r; raddr = AW'(p_r - NW'(1));
    case (state_r)
      S_IDLE: begin
        if (start && !busy) begin
          op_nxt = in_opcode; val_nxt = in_operand_value; acc_nxt = '0;
          st_nxt = ST_OK; p_nxt = cnt_r; srch_hit_nxt = 1'b0;
          raddr = AW'(cnt_r - NW'(1));
          state_nxt = S_DONE;
          case (in_opcode)
            OP_PUSH, OP_INSERT: begin
              if (cnt_r == DEPTH_N) st_nxt = ST_FULL;
              else if (in_opcode == OP_PUSH) begin
                we = 1'b1; waddr = AW'(cnt_r); wdata = in_operand_value;
                cnt_nxt = cnt_r + NW'(1);
              end else if (cnt_r == '0) begin
                we = 1'b1; waddr = '0; wdata = in_operand_value;
                cnt_nxt = NW'(1);
              end else state_nxt = S_RD;
            end
            OP_POP, OP_MIN, OP_SORT: begin
              if (cnt_r == '0) st_nxt = ST_EMPTY;
              else if (in_opcode == OP_SORT) begin
                if (cnt_r != NW'(1)) begin
                  i_nxt = NW'(1); raddr = AW'(1); state_nxt = S_SKEY;
                end
              end else begin
                if (in_opcode == OP_MIN) raddr = '0;
                state_nxt = S_RD;
                p_nxt = (in_opcode == OP_MIN) ? NW'(1) : cnt_r;
              end
            end
            OP_SEARCH: if (cnt_r != '0) state_nxt = S_RD;
            OP_SIZE: acc_nxt = VAL_W'(cnt_r);
            default: ;
          endcase
        end
      end
      S_RD: state_nxt = S_EVAL;
      S_EVAL: begin
        case (op_r)
          OP_POP: begin
            acc_nxt = rdata; cnt_nxt = cnt_r - NW'(1); state_nxt = S_DONE;
          end
          OP_MIN: begin
            if (p_r == NW'(1) || cmp_lt) acc_nxt = rdata;
            if (p_r == cnt_r) state_nxt = S_DONE;
            else begin
              p_nxt = p_r + NW'(1); raddr = AW'(p_r); state_nxt = S_RD;
            end
          end
          OP_SEARCH: begin
            if (cmp_eq) begin
              acc_nxt = VAL_W'(cnt_r - p_r + NW'(1)); state_nxt = S_DONE;
            end else if (p_r == NW'(1)) state_nxt = S_DONE;
            else begin
              p_nxt = p_r - NW'(1); raddr = AW'(p_r - NW'(2)); state_nxt = S_RD;
            end
          end
          OP_INSERT, OP_SORT: begin
            if (cmp_lt) begin
              // Shift the smaller entry up one place
              we = 1'b1; waddr = AW'(p_r); wdata = rdata;
              if (p_r == NW'(1)) begin
                // Bottom reached: drop the key in at entry zero next cycle
                p_nxt = '0; srch_hit_nxt = 1'b0; state_nxt = S_SKEYD;
              end else begin
                p_nxt = p_r - NW'(1); raddr = AW'(p_r - NW'(2)); state_nxt = S_RD;
              end
            end else begin
              // Drop the key in above the first entry not below it
              we = 1'b1; waddr = AW'(p_r); wdata = val_r;
              srch_hit_nxt = 1'b1;
              if (op_r == OP_INSERT) begin
                cnt_nxt = cnt_r + NW'(1); state_nxt = S_DONE;
              end else state_nxt = S_SKEYD;
            end
          end
          default: state_nxt = S_DONE;
        endcase
      end
      S_SKEYD: begin
        // Write the key at p unless it was already placed
        if (!srch_hit_r) begin
          we = 1'b1; waddr = AW'(p_r); wdata = val_r;
        end
        if (op_r == OP_INSERT) begin
          cnt_nxt = cnt_r + NW'(1); state_nxt = S_DONE;
        end else if (i_r + NW'(1) == cnt_r) state_nxt = S_DONE;
        else begin
          i_nxt = i_r + NW'(1); raddr = AW'(i_r + NW'(1)); state_nxt = S_SKEY;
        end
      end
      S_SKEY: begin
        // Latch the key, then walk down from i-1
        val_nxt = rdata;
        p_nxt = i_r; raddr = AW'(i_r - NW'(1));
        state_nxt = S_RD;
      end
      S_DONE: begin
        ov_nxt = 1'b1; state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE; cnt_r <= '0; ov_r <= 1'b0;
    end else begin
      state_r <= state_nxt; cnt_r <= cnt_nxt; ov_r <= ov_nxt;
    end
    op_r <= op_nxt; val_r <= val_nxt; acc_r <= acc_nxt; p_r <= p_nxt;
    i_r <= i_nxt; st_r <= st_nxt; srch_hit_r <= srch_hit_nxt;
  end

  assign busy             = (state_r != S_IDLE) || ov_r;
  assign out_valid        = ov_r;
  assign out_status       = st_r;
  assign out_result_value = acc_r;
  assign out_entry_count  = CNT_W'(cnt_r);

  // Count never exceeds depth
  a_cnt: assert property (@(posedge clk) disable iff (!rst_n) cnt_r <= DEPTH_N)
    else $error("count beyond depth");
  // A result strobe is never followed directly by another
  a_one: assert property (@(posedge clk) disable iff (!rst_n) ov_r |=> !ov_r)
    else $error("double result");
  // Failed commands give zero value
  a_fail: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && st_r != ST_OK) |-> acc_r == '0) else $error("failed result nonzero");
endmodule

@@ verif/sse_checker.sv @@
// Checker for the sorted stack engine: predicts each result from the accepted command words
// and compares it with what the block strobes out. Depends on sse_pkg.
module sse_checker
  import sse_pkg::*;
#(
  parameter int STACK_DEPTH = 64
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic                    busy,
  input  logic [2:0]              in_opcode,
  input  logic signed [VAL_W-1:0] in_operand_value,
  input  logic                    out_valid,
  input  logic [1:0]              out_status,
  input  logic signed [VAL_W-1:0] out_result_value,
  input  logic [CNT_W-1:0]        out_entry_count,
  output int                      mismatch_count,
  output int                      pending_count,
  output int                      result_count,
  output int                      full_count,
  output int                      empty_count
);

  typedef struct packed {
    logic [1:0]       status;
    word_t            value;
    logic [CNT_W-1:0] count;
  } stack_result_t;

  word_t         stack_copy [STACK_DEPTH];
  int            depth_held;
  stack_result_t awaited_results [$];

  // Print one line and count the mismatch
  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("tb: mismatch on %s at result %0d: got %0d, want %0d",
             what, result_count, got, want);
    mismatch_count++;
  endtask

  // Apply one command to the shadow stack and return its result word
  function automatic stack_result_t apply_command(input logic [2:0] op, input word_t val);
    stack_result_t r;
    int            p;
    int            j;
    word_t         key;
    r.status = ST_OK;
    r.value  = '0;
    case (op)
      OP_PUSH: begin
        if (depth_held >= STACK_DEPTH) r.status = ST_FULL;
        else begin
          stack_copy[depth_held] = val;
          depth_held++;
        end
      end
      OP_POP: begin
        if (depth_held == 0) r.status = ST_EMPTY;
        else begin
          r.value = stack_copy[depth_held-1];
          depth_held--;
        end
      end
      OP_INSERT: begin
        if (depth_held >= STACK_DEPTH) r.status = ST_FULL;
        else begin
          p = depth_held;
          while (p > 0 && stack_copy[p-1] < val) p--;
          for (j = depth_held; j > p; j--) stack_copy[j] = stack_copy[j-1];
          stack_copy[p] = val;
          depth_held++;
        end
      end
      OP_SEARCH: begin
        for (j = 0; j < depth_held; j++)
          if (stack_copy[depth_held-1-j] == val) begin
            r.value = j + 1;
            break;
          end
      end
      OP_MIN: begin
        if (depth_held == 0) r.status = ST_EMPTY;
        else begin
          r.value = stack_copy[0];
          for (j = 1; j < depth_held; j++)
            if (stack_copy[j] < r.value) r.value = stack_copy[j];
        end
      end
      OP_SIZE: r.value = depth_held;
      OP_SORT: begin
        if (depth_held == 0) r.status = ST_EMPTY;
        else begin
          // insertion sort, largest at the bottom
          for (int i = 1; i < depth_held; i++) begin
            key = stack_copy[i];
            j = i;
            while (j > 0 && stack_copy[j-1] < key) begin
              stack_copy[j] = stack_copy[j-1];
              j--;
            end
            stack_copy[j] = key;
          end
        end
      end
      default: ;
    endcase
    r.count = depth_held[CNT_W-1:0];
    return r;
  endfunction

  initial begin
    mismatch_count = 0;
    result_count   = 0;
    full_count     = 0;
    empty_count    = 0;
    depth_held     = 0;
  end

  assign pending_count = awaited_results.size();

  // Compare strobed results, then predict from accepted command words
  always @(posedge clk) begin
    stack_result_t want;
    if (rst_n) begin
      if (out_valid) begin
        if (awaited_results.size() == 0) begin
          report_mismatch("unexpected result status", {62'd0, out_status}, '0);
        end else begin
          want = awaited_results.pop_front();
          if (out_status !== want.status)
            report_mismatch("status", out_status, want.status);
          if (out_result_value !== want.value)
            report_mismatch("result_value", out_result_value, want.value);
          if (out_entry_count !== want.count)
            report_mismatch("entry_count", out_entry_count, want.count);
          if (want.status == ST_FULL) full_count++;
          if (want.status == ST_EMPTY) empty_count++;
        end
        result_count++;
      end
      if (start && !busy)
        awaited_results.push_back(apply_command(in_opcode, in_operand_value));
    end
  end

endmodule

@@ verif/testbench.sv @@
// Top of the sorted stack engine testbench: clock, reset, command stimulus and verdict.
// Depends on sse_pkg, sorted_stack_engine_top and sse_checker.
module testbench;
  import sse_pkg::*;

  localparam int DEPTH       = 64;
  localparam int RANDOM_WORDS = 1550;
  localparam int IDLE_LIMIT  = 40000;

  logic                    clk;
  logic                    rst_n;
  logic                    start;
  logic                    busy;
  logic [2:0]              in_opcode;
  logic signed [VAL_W-1:0] in_operand_value;
  logic                    out_valid;
  logic [1:0]              out_status;
  logic signed [VAL_W-1:0] out_result_value;
  logic [CNT_W-1:0]        out_entry_count;

  int mismatch_count, pending_count, result_count, full_count, empty_count;
  int accepted_words;
  int idle_cycles;
  int held_guess;

  sorted_stack_engine_top #(.STACK_DEPTH(DEPTH)) dut (.*);

  sse_checker #(.STACK_DEPTH(DEPTH)) checker_i (.*);

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Watchdog: count cycles where nothing moves on either channel
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb: watchdog expired after %0d idle cycles", idle_cycles);
      $display("tb: failure");
      $finish;
    end
  end

  // Present one command word and hold it until accepted; optionally idle afterwards
  task automatic send_word(input logic [2:0] op, input word_t val);
    int gap;
    start            <= 1'b1;
    in_opcode        <= op;
    in_operand_value <= val;
    do @(posedge clk); while (busy);
    accepted_words++;
    // track the fill level roughly for steering the random mix
    case (op)
      OP_PUSH, OP_INSERT: if (held_guess < DEPTH) held_guess++;
      OP_POP:             if (held_guess > 0) held_guess--;
      default: ;
    endcase
    gap = $urandom_range(0, 99);
    if (gap >= 70) begin
      start <= 1'b0;
      repeat (gap >= 96 ? $urandom_range(10, 40) : $urandom_range(1, 3)) @(posedge clk);
    end
  endtask

  function automatic word_t pick_value();
    int k;
    k = $urandom_range(0, 9);
    if (k < 5) return $signed($urandom_range(0, 16)) - 8;
    if (k == 5) return 32'sh8000_0000;
    if (k == 6) return 32'sh7fff_ffff;
    return $urandom;
  endfunction

  initial begin
    int    mode;
    int    roll;
    logic [2:0] op;
    rst_n            = 1'b0;
    start            = 1'b0;
    in_opcode        = OP_SIZE;
    in_operand_value = '0;
    accepted_words   = 0;
    idle_cycles      = 0;
    held_guess       = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty cases, extremes, each command, unused opcode
    send_word(OP_POP, 0);
    send_word(OP_MIN, 0);
    send_word(OP_SORT, 0);
    send_word(OP_SEARCH, 5);
    send_word(OP_SIZE, -1);
    send_word(OP_SPARE, 32'sh7fff_ffff);
    send_word(OP_PUSH, 32'sh7fff_ffff);
    send_word(OP_PUSH, 32'sh8000_0000);
    send_word(OP_PUSH, 0);
    send_word(OP_PUSH, -1);
    send_word(OP_INSERT, 5);
    send_word(OP_INSERT, 5);
    send_word(OP_INSERT, 32'sh8000_0000);
    send_word(OP_SEARCH, 5);
    send_word(OP_SEARCH, 32'sh7fff_ffff);
    send_word(OP_SEARCH, 42);
    send_word(OP_MIN, 0);
    send_word(OP_SIZE, 0);
    send_word(OP_SORT, 0);
    send_word(OP_POP, 0);
    send_word(OP_MIN, 0);
    send_word(OP_SPARE, -1);
    send_word(OP_SIZE, 0);

    // Random: bursts that fill, drain or mix, so full and empty both occur
    mode = 0;
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      if (n % 40 == 0) mode = $urandom_range(0, 2);
      if (mode == 0 && held_guess >= DEPTH) mode = 1;
      if (mode == 1 && held_guess == 0) mode = 0;
      roll = $urandom_range(0, 99);
      if (roll < 2) op = OP_SORT;
      else if (roll < 3) op = OP_SPARE;
      else if (roll < 13) op = OP_SEARCH;
      else if (roll < 19) op = OP_MIN;
      else if (roll < 23) op = OP_SIZE;
      else begin
        roll = $urandom_range(0, 99);
        case (mode)
          0:       op = roll < 80 ? (roll < 45 ? OP_PUSH : OP_INSERT) : OP_POP;
          1:       op = roll < 75 ? OP_POP : (roll < 88 ? OP_PUSH : OP_INSERT);
          default: op = roll < 50 ? OP_POP : (roll < 75 ? OP_PUSH : OP_INSERT);
        endcase
      end
      send_word(op, pick_value());
    end
    start <= 1'b0;

    // Drain: wait until every result is in, then a short settle
    while (pending_count != 0) @(posedge clk);
    repeat (200) @(posedge clk);

    $display("tb: %0d command words accepted, %0d results checked", accepted_words,
             result_count);
    $display("tb: %0d full and %0d empty rejections seen", full_count, empty_count);
    if (mismatch_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
